// ----- sv/wbfc_pkg.sv -----
`default_nettype none

package wbfc_pkg;

    // item kinds
    localparam logic [1:0] KIND_ENSURE     = 2'd0;
    localparam logic [1:0] KIND_WRITE      = 2'd1;
    localparam logic [1:0] KIND_FLUSH_DONE = 2'd2;
    localparam logic [1:0] KIND_FETCH_DONE = 2'd3;

    // result actions
    localparam logic [2:0] ACT_READY   = 3'd0;
    localparam logic [2:0] ACT_IGNORED = 3'd1;
    localparam logic [2:0] ACT_FETCH   = 3'd2;
    localparam logic [2:0] ACT_WRITE   = 3'd3;
    localparam logic [2:0] ACT_ERROR   = 3'd4;

    // configuration register indexes
    localparam logic CFG_NUM_BLOCKS = 1'b0;
    localparam logic CFG_SCAN_SEED  = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 9;
    localparam int LFSR_W     = 16;

    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [7:0]        STATUS_OK  = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] block;
        logic [7:0] status;
    } in_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] target_block;
        logic       busy_res;
        logic [7:0] last_status;
        logic       last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SCAN_INIT,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic scan_init;
        logic scan_a;
        logic scan_b;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_kick;
        logic has_result;
        logic div_last;
        logic hit;
        logic a_end;
        logic b_end;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/wbfc_ctrl.sv -----
`default_nettype none

module wbfc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire wbfc_pkg::sts_t sts,
    output wbfc_pkg::cmd_t      cmd
);

    wbfc_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wbfc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wbfc_pkg::ST_IDLE: begin
                if (s_valid) state_next = wbfc_pkg::ST_EVAL;
            end
            wbfc_pkg::ST_EVAL: begin
                priority if (sts.go_kick) state_next = wbfc_pkg::ST_DIV;
                else if (sts.has_result) state_next = wbfc_pkg::ST_RESULT;
                else state_next = wbfc_pkg::ST_IDLE;
            end
            wbfc_pkg::ST_DIV: begin
                if (sts.div_last) state_next = wbfc_pkg::ST_SCAN_INIT;
            end
            wbfc_pkg::ST_SCAN_INIT: begin
                state_next = wbfc_pkg::ST_SCAN_A;
            end
            wbfc_pkg::ST_SCAN_A: begin
                priority if (sts.hit) state_next = wbfc_pkg::ST_RESULT;
                else if (sts.a_end) state_next = wbfc_pkg::ST_SCAN_B;
                else state_next = wbfc_pkg::ST_SCAN_A;
            end
            wbfc_pkg::ST_SCAN_B: begin
                if (sts.hit || sts.b_end) state_next = wbfc_pkg::ST_RESULT;
            end
            wbfc_pkg::ST_RESULT: begin
                if (sts.out_free) state_next = wbfc_pkg::ST_IDLE;
            end
            default: state_next = wbfc_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            wbfc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            wbfc_pkg::ST_EVAL:      cmd.eval      = 1'b1;
            wbfc_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            wbfc_pkg::ST_SCAN_INIT: cmd.scan_init = 1'b1;
            wbfc_pkg::ST_SCAN_A:    cmd.scan_a    = 1'b1;
            wbfc_pkg::ST_SCAN_B:    cmd.scan_b    = 1'b1;
            wbfc_pkg::ST_RESULT:    cmd.emit      = sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/wbfc_datapath.sv -----
`default_nettype none

module wbfc_datapath #(
    parameter int MAX_BLOCKS = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire wbfc_pkg::cmd_t                     cmd,
    output wbfc_pkg::sts_t                          sts,
    input  wire wbfc_pkg::in_word_t                 s_word,
    output wbfc_pkg::out_word_t                     m_word,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_addr,
    input  wire logic [wbfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
    localparam int BI_W  = $clog2(DEPTH);
    localparam int NCH   = (DEPTH + 7) / 8;
    localparam int CH_W  = $clog2(NCH + 1);
    localparam int PAD_W = (NCH + 1) * 8;
    localparam int CW    = wbfc_pkg::COUNT_W;
    localparam int LW    = wbfc_pkg::LFSR_W;

    // registers
    wbfc_pkg::in_word_t  item_reg, item_next;
    logic [CW-1:0]       num_blocks_reg, num_blocks_next;
    logic [LW-1:0]       lfsr_reg, lfsr_next;
    logic [DEPTH-1:0]    valid_reg, valid_next;
    logic [DEPTH-1:0]    dirty_reg, dirty_next;
    logic                flushing_reg, flushing_next;
    logic [7:0]          flush_target_reg, flush_target_next;
    logic                miss_pending_reg, miss_pending_next;
    logic                fetch_deferred_reg, fetch_deferred_next;
    logic [7:0]          miss_target_reg, miss_target_next;
    logic [7:0]          status_hold_reg, status_hold_next;
    logic [2:0]          res_act_reg, res_act_next;
    logic [7:0]          res_tgt_reg, res_tgt_next;
    logic [7:0]          rem_reg, rem_next;
    logic [3:0]          div_cnt_reg, div_cnt_next;
    logic [CH_W-1:0]     chunk_reg, chunk_next;
    logic                out_valid_reg, out_valid_next;
    wbfc_pkg::out_word_t out_word_reg, out_word_next;

    // effective block count
    logic [CW-1:0] eff;
    assign eff = (num_blocks_reg > CW'(DEPTH)) ? CW'(DEPTH) : num_blocks_reg;

    // item decision
    logic [2:0] ev_act;
    logic [7:0] ev_tgt;
    logic       ev_want_kick;
    logic       ev_go;
    logic       ev_has;
    logic       out_of_range;
    logic       blk_present;
    logic       kick_blocked;

    assign out_of_range = {1'b0, item_reg.block} >= eff;
    assign blk_present  = valid_reg[item_reg.block[BI_W-1:0]]
                        | dirty_reg[item_reg.block[BI_W-1:0]];

    always_comb begin
        ev_act       = wbfc_pkg::ACT_READY;
        ev_tgt       = 8'd0;
        ev_want_kick = 1'b0;
        ev_has       = 1'b1;
        kick_blocked = flushing_reg;
        unique case (item_reg.kind)
            wbfc_pkg::KIND_ENSURE: begin
                priority if (out_of_range) ev_act = wbfc_pkg::ACT_ERROR;
                else if (blk_present) ev_act = wbfc_pkg::ACT_READY;
                else if (miss_pending_reg) ev_act = wbfc_pkg::ACT_IGNORED;
                else if (flushing_reg) ev_has = 1'b0;
                else begin
                    ev_act = wbfc_pkg::ACT_FETCH;
                    ev_tgt = item_reg.block;
                end
            end
            wbfc_pkg::KIND_WRITE: begin
                if (out_of_range) ev_act = wbfc_pkg::ACT_ERROR;
                else ev_want_kick = 1'b1;
            end
            wbfc_pkg::KIND_FLUSH_DONE: begin
                // flushing is cleared by this item before any kick
                kick_blocked = 1'b0;
                priority if (!flushing_reg) ev_act = wbfc_pkg::ACT_IGNORED;
                else if (miss_pending_reg && fetch_deferred_reg) begin
                    ev_act = wbfc_pkg::ACT_FETCH;
                    ev_tgt = miss_target_reg;
                end else if (miss_pending_reg) ev_act = wbfc_pkg::ACT_READY;
                else ev_want_kick = 1'b1;
            end
            wbfc_pkg::KIND_FETCH_DONE: begin
                if (!miss_pending_reg || fetch_deferred_reg) ev_act = wbfc_pkg::ACT_IGNORED;
                else ev_want_kick = 1'b1;
            end
            default: ;
        endcase
        ev_go = ev_want_kick && !kick_blocked && (eff != '0);
    end

    // restoring division step for the scan start
    logic [8:0] div_trial;
    assign div_trial = {rem_reg, lfsr_reg[~div_cnt_reg]};

    // scan window of eight dirty bits
    logic [PAD_W-1:0] dirty_pad;
    logic [7:0]       chunk_bits;
    logic [7:0]       hit_mask;
    logic [2:0]       hit_pos;
    logic [CW-1:0]    lane_idx [8];
    logic [CW-1:0]    start_ext;
    logic [CW-1:0]    hit_idx;
    logic [CW:0]      next_base;
    logic [CW-1:0]    sp1;

    assign dirty_pad  = PAD_W'(dirty_reg);
    assign chunk_bits = dirty_pad[{chunk_reg, 3'b000} +: 8];
    assign start_ext  = CW'(rem_reg);
    assign sp1        = start_ext + CW'(1);
    assign next_base  = (CW + 1)'({chunk_reg, 3'b000}) + (CW + 1)'(8);

    always_comb begin
        hit_pos = 3'd0;
        for (int j = 0; j < 8; j++) begin
            lane_idx[j] = CW'({chunk_reg, 3'(j)});
            if (cmd.scan_a) begin
                hit_mask[j] = chunk_bits[j] && (lane_idx[j] > start_ext)
                            && (lane_idx[j] < eff);
            end else begin
                hit_mask[j] = chunk_bits[j] && (lane_idx[j] <= start_ext);
            end
        end
        for (int j = 7; j >= 0; j--) begin
            if (hit_mask[j]) hit_pos = 3'(j);
        end
    end

    assign hit_idx = CW'({chunk_reg, hit_pos});

    // status to controller
    always_comb begin
        sts.go_kick    = ev_go;
        sts.has_result = ev_has;
        sts.div_last   = &div_cnt_reg;
        sts.hit        = |hit_mask;
        sts.a_end      = next_base >= (CW + 1)'(eff);
        sts.b_end      = CW'(chunk_reg) == CW'(rem_reg[7:3]);
        sts.out_free   = !out_valid_reg || m_ready;
    end

    // next values
    always_comb begin
        item_next           = item_reg;
        num_blocks_next     = num_blocks_reg;
        lfsr_next           = lfsr_reg;
        valid_next          = valid_reg;
        dirty_next          = dirty_reg;
        flushing_next       = flushing_reg;
        flush_target_next   = flush_target_reg;
        miss_pending_next   = miss_pending_reg;
        fetch_deferred_next = fetch_deferred_reg;
        miss_target_next    = miss_target_reg;
        status_hold_next    = status_hold_reg;
        res_act_next        = res_act_reg;
        res_tgt_next        = res_tgt_reg;
        rem_next            = rem_reg;
        div_cnt_next        = div_cnt_reg;
        chunk_next          = chunk_reg;
        out_valid_next      = out_valid_reg;
        out_word_next       = out_word_reg;

        if (cmd.load) item_next = s_word;

        // apply the item to the block state
        if (cmd.eval) begin
            res_act_next = ev_act;
            res_tgt_next = ev_tgt;
            unique case (item_reg.kind)
                wbfc_pkg::KIND_ENSURE: begin
                    if (!out_of_range && !blk_present && !miss_pending_reg) begin
                        miss_pending_next   = 1'b1;
                        miss_target_next    = item_reg.block;
                        fetch_deferred_next = flushing_reg;
                    end
                end
                wbfc_pkg::KIND_WRITE: begin
                    if (!out_of_range) begin
                        valid_next[item_reg.block[BI_W-1:0]] = 1'b1;
                        dirty_next[item_reg.block[BI_W-1:0]] = 1'b1;
                    end
                end
                wbfc_pkg::KIND_FLUSH_DONE: begin
                    if (flushing_reg) begin
                        status_hold_next = item_reg.status;
                        if (item_reg.status != wbfc_pkg::STATUS_OK) begin
                            dirty_next[flush_target_reg[BI_W-1:0]] = 1'b1;
                        end
                        flushing_next = 1'b0;
                        if (miss_pending_reg) fetch_deferred_next = 1'b0;
                    end
                end
                wbfc_pkg::KIND_FETCH_DONE: begin
                    if (miss_pending_reg && !fetch_deferred_reg) begin
                        valid_next[miss_target_reg[BI_W-1:0]] = 1'b1;
                        miss_pending_next = 1'b0;
                    end
                end
                default: ;
            endcase
            if (ev_go) begin
                lfsr_next    = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ wbfc_pkg::LFSR_MASK)
                                           : (lfsr_reg >> 1);
                rem_next     = 8'd0;
                div_cnt_next = 4'd0;
            end
        end

        // one quotient bit per cycle, remainder is the scan start
        if (cmd.div_step) begin
            if (div_trial >= eff) rem_next = 8'(div_trial - eff);
            else rem_next = div_trial[7:0];
            div_cnt_next = div_cnt_reg + 4'd1;
        end

        if (cmd.scan_init) chunk_next = CH_W'(sp1 >> 3);

        // circular scan: above the start first, then from block zero
        if (cmd.scan_a || cmd.scan_b) begin
            priority if (sts.hit) begin
                dirty_next[hit_idx[BI_W-1:0]] = 1'b0;
                flushing_next     = 1'b1;
                flush_target_next = hit_idx[7:0];
                res_act_next      = wbfc_pkg::ACT_WRITE;
                res_tgt_next      = hit_idx[7:0];
            end else if (cmd.scan_a && sts.a_end) begin
                chunk_next = '0;
            end else if (cmd.scan_a || !sts.b_end) begin
                chunk_next = chunk_reg + CH_W'(1);
            end else begin
                chunk_next = chunk_reg;
            end
        end

        // output register
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if (cmd.emit) begin
            out_valid_next             = 1'b1;
            out_word_next.action       = res_act_reg;
            out_word_next.target_block = res_tgt_reg;
            out_word_next.busy_res     = flushing_reg;
            out_word_next.last_status  = status_hold_reg;
            out_word_next.last         = 1'b1;
        end

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                wbfc_pkg::CFG_NUM_BLOCKS: num_blocks_next = cfg_wdata[CW-1:0];
                wbfc_pkg::CFG_SCAN_SEED:  lfsr_next       = cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blocks_reg     <= '0;
            lfsr_reg           <= wbfc_pkg::SEED_RESET;
            valid_reg          <= '0;
            dirty_reg          <= '0;
            flushing_reg       <= 1'b0;
            flush_target_reg   <= 8'd0;
            miss_pending_reg   <= 1'b0;
            fetch_deferred_reg <= 1'b0;
            miss_target_reg    <= 8'd0;
            status_hold_reg    <= 8'd0;
            out_valid_reg      <= 1'b0;
        end else begin
            num_blocks_reg     <= num_blocks_next;
            lfsr_reg           <= lfsr_next;
            valid_reg          <= valid_next;
            dirty_reg          <= dirty_next;
            flushing_reg       <= flushing_next;
            flush_target_reg   <= flush_target_next;
            miss_pending_reg   <= miss_pending_next;
            fetch_deferred_reg <= fetch_deferred_next;
            miss_target_reg    <= miss_target_next;
            status_hold_reg    <= status_hold_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        res_act_reg  <= res_act_next;
        res_tgt_reg  <= res_tgt_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        chunk_reg    <= chunk_next;
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

`default_nettype wire

// ----- sv/writeback_block_flush_controller_top.sv -----
`default_nettype none

// Flush controller for a write-back block cache. Each input word is an ensure,
// a write, a flush-write completion or a fetch completion, and each produces
// one result word (fetch, block write, ready, ignored or error) carrying the
// in-flight flag and the last flush status; an ensure for an absent block that
// arrives during a flush with no fetch pending produces no word, and its fetch
// comes out with the next flush completion. Valid and dirty bits live in
// flip-flops cleared at reset, so there is no clearing pass. Words are handled
// one at a time: a word without a flush kick passes through the evaluate state
// and, if it has a result, the result state, and the next word is taken once
// the controller is back in idle. A kick steps the scan LFSR and reduces it
// modulo the block count in a one-bit-per-cycle divider, then scans the dirty
// map eight bits per cycle. The next word is accepted while a result still
// waits in the output register. num_blocks and scan_seed must be written
// through the cfg port only while idle; the block itself does not enforce it.
module writeback_block_flush_controller_top #(
    parameter int MAX_BLOCKS = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire wbfc_pkg::in_word_t                 s_word,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output wbfc_pkg::out_word_t                     m_word,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_addr,
    input  wire logic [wbfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    wbfc_pkg::cmd_t cmd;
    wbfc_pkg::sts_t sts;

    // sequencer
    wbfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // block state, divider, scanner and output register
    wbfc_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_word    (s_word),
        .m_word    (m_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire
